>>> design/shortest_path_distance_defines.svh
// Assertion macros for the shortest path distance block.
// Used by the top level only.
`ifndef SHORTEST_PATH_DISTANCE_DEFINES_SVH
`define SHORTEST_PATH_DISTANCE_DEFINES_SVH
// check a property each clock edge outside reset
`define SPD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check a property including reset cycles
`define SPD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

>>> design/spd_pkg.sv
// Shared types and constants for the shortest path distance block.
// No dependencies.
package spd_pkg;
   localparam int unsigned DIST_BITS = 24;
   localparam logic [DIST_BITS-1:0] DIST_SAT = '1;
   localparam logic [7:0] REG_SOURCE = 8'd0;
   localparam logic [7:0] REG_DEST   = 8'd1;

   typedef struct packed {
      logic [7:0]  from_node;
      logic [7:0]  to_node;
      logic [15:0] edge_weight;
      logic        last_edge;
   } req_type;

   typedef struct packed {
      logic [23:0] shortest_distance;
      logic        reachable;
      logic        edges_dropped;
   } rsp_type;
endpackage

>>> design/shortest_path_distance.sv
// Shortest path distance block: edge loader, search sequencer, CSR port.
// Depends on spd_pkg, spd_ram and shortest_path_distance_defines.svh.
//
// Usage: raise req_start with req_data (one edge) while busy is low; each
// accepted transaction stores one edge, or sets the dropped flag if the edge
// RAM is full. Setting last_edge starts the search; busy stays high until the result.
// Search: one clear pass over the distance RAM, then per round a scan of
// all nodes to pick the closest unsettled one and a scan of all stored
// edges to relax its out-edges; both scans are set by the single read port
// of each RAM. rsp_valid rises in the same cycle in which busy drops.
// Result: rsp_valid pulses for one cycle with rsp_data; the receiver
// cannot stall, so nothing waits. Edge count and dropped flag then clear.
// Reset (synchronous): clears counters, flags and the CSRs (source and
// destination 0); the edge RAM keeps no reset value.
// CSR: APB-style, source_node at 0x0, dest_node at 0x4, pready always high.
`include "shortest_path_distance_defines.svh"
module shortest_path_distance import spd_pkg::*; #(
   parameter int NODE_COUNT  = 256,
   parameter int EDGE_DEPTH  = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   // node ids are 8 bits and weights 16 bits, so nothing wider is ever used
   localparam int NU = (NODE_COUNT < 256) ? NODE_COUNT : 256;
   localparam int WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
   localparam int NB = (NU > 2) ? $clog2(NU) : 1;
   localparam int EB = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
   localparam int CB = $clog2(EDGE_DEPTH + 1);
   localparam int NCB = $clog2(NU + 1);
   localparam int EW = 16 + WB;
   localparam int DW = DIST_BITS + 2; // valid, settled, distance

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MARK  = 3'd3;
   localparam logic [2:0] ST_RELAX = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [7:0] src_ff, dst_ff;
   logic [CB-1:0] count_ff, count_in;
   logic over_ff, over_in;
   logic [NCB-1:0] idx_ff, idx_in;     // node sweep index
   logic [CB-1:0] eidx_ff, eidx_in;    // edge sweep index
   logic rd_ok_ff, rd_ok_in;           // read data of the previous cycle is wanted
   logic [NB-1:0] rd_node_ff, rd_node_in;
   logic found_ff, found_in;
   logic [NB-1:0] best_ff, best_in;
   logic [DIST_BITS-1:0] bestd_ff, bestd_in;
   logic [NB-1:0] head_ff;
   logic [DIST_BITS-1:0] cand_ff;
   logic cand_ok_ff, cand_ok_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic [DIST_BITS-1:0] cand_in;
   logic [NB-1:0] head_in;

   logic e_we; logic [EB-1:0] e_wa, e_ra; logic [EW-1:0] e_wd, e_rd;
   logic d_we; logic [NB-1:0] d_wa, d_ra; logic [DW-1:0] d_wd, d_rd;

   spd_ram #(.WIDTH(EW), .DEPTH(EDGE_DEPTH)) u_edge (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   spd_ram #(.WIDTH(DW), .DEPTH(NU)) u_dist (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   wire accept = req_start && !busy;
   wire src_ok = {24'd0, src_ff} < NODE_COUNT;
   wire dst_ok = {24'd0, dst_ff} < NODE_COUNT;
   wire csr_wr = csr_psel && csr_penable && csr_pwrite;

   // edge entry fields
   wire [7:0] e_tail = e_rd[EW-1 -: 8];
   wire [7:0] e_head = e_rd[EW-9 -: 8];
   wire [WB-1:0] e_len = e_rd[WB-1:0];
   wire d_valid = d_rd[DW-1];
   wire d_set = d_rd[DW-2];
   wire [DIST_BITS-1:0] d_dist = d_rd[DIST_BITS-1:0];
   wire [DIST_BITS:0] sum = {1'b0, bestd_ff} + (DIST_BITS+1)'(e_len);

   always_comb begin
      state_in = state_ff; count_in = count_ff; over_in = over_ff;
      idx_in = idx_ff; eidx_in = eidx_ff; rd_ok_in = 1'b0; rd_node_in = rd_node_ff;
      found_in = found_ff; best_in = best_ff; bestd_in = bestd_ff;
      cand_ok_in = 1'b0; cand_in = cand_ff; head_in = head_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      e_we = 1'b0; e_wa = count_ff[EB-1:0];
      e_wd = {req_data.from_node, req_data.to_node, req_data.edge_weight[WB-1:0]};
      e_ra = eidx_ff[EB-1:0];
      d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = idx_ff[NB-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CB'(EDGE_DEPTH)) begin
                  e_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  over_in = 1'b1;
               end
               if (req_data.last_edge) begin
                  state_in = ST_CLEAR;
                  idx_in = '0;
               end
            end
         end
         ST_CLEAR: begin
            d_we = 1'b1; d_wa = idx_ff[NB-1:0];
            d_wd = (src_ok && idx_ff[NB-1:0] == src_ff[NB-1:0] &&
                    {24'd0, src_ff} == 32'(idx_ff)) ? {1'b1, 1'b0, {DIST_BITS{1'b0}}}
                                                    : {1'b0, 1'b0, DIST_SAT};
            idx_in = idx_ff + 1'b1;
            if (idx_ff == NCB'(NU - 1)) begin
               state_in = ST_SCAN; idx_in = '0; found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue reads for nodes in order, compare when the read data returns in the next cycle
            if (rd_ok_ff && d_valid && !d_set && (!found_ff || d_dist < bestd_ff)) begin
               found_in = 1'b1; best_in = rd_node_ff; bestd_in = d_dist;
            end
            if (idx_ff < NCB'(NU)) begin
               d_ra = idx_ff[NB-1:0]; rd_ok_in = 1'b1; rd_node_in = idx_ff[NB-1:0];
               idx_in = idx_ff + 1'b1;
            end else if (!rd_ok_ff) begin
               state_in = found_ff ? ST_MARK : ST_DONE;
            end
         end
         ST_MARK: begin
            d_we = 1'b1; d_wa = best_ff; d_wd = {1'b1, 1'b1, bestd_ff};
            state_in = ST_RELAX; eidx_in = '0;
         end
         ST_RELAX: begin
            // pipeline: edge read -> distance read -> compare/write
            if (cand_ok_ff && (!d_valid || cand_ff < d_dist)) begin
               d_we = 1'b1; d_wa = head_ff; d_wd = {1'b1, d_set, cand_ff};
            end
            if (rd_ok_ff && {24'd0, e_tail} == 32'(best_ff) &&
                {24'd0, e_head} < NODE_COUNT) begin
               cand_ok_in = 1'b1;
               head_in = e_head[NB-1:0];
               cand_in = sum[DIST_BITS] ? DIST_SAT : sum[DIST_BITS-1:0];
               d_ra = e_head[NB-1:0];
               // back-to-back to the same head: forward by stalling is not needed,
               // the earlier write lands now; use the smaller candidate
               if (cand_ok_ff && e_head[NB-1:0] == head_ff) begin
                  cand_ok_in = 1'b0;
                  if ((!d_valid || cand_ff < d_dist) ? (cand_in < cand_ff)
                                                     : (cand_in < d_dist)) begin
                     cand_ok_in = 1'b1;
                  end
               end
            end
            if (eidx_ff < count_ff) begin
               e_ra = eidx_ff[EB-1:0]; rd_ok_in = 1'b1; eidx_in = eidx_ff + 1'b1;
            end else if (!rd_ok_ff && !cand_ok_ff) begin
               state_in = ST_SCAN; idx_in = '0; found_in = 1'b0;
            end
         end
         ST_DONE: begin
            // read destination entry then report
            if (!rd_ok_ff) begin
               d_ra = dst_ff[NB-1:0]; rd_ok_in = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.reachable = dst_ok && d_valid;
               rsp_in.shortest_distance = (dst_ok && d_valid) ? d_dist : '0;
               rsp_in.edges_dropped = over_ff;
               count_in = '0; over_in = 1'b0; state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // state, counters, flags and CSR registers, with synchronous reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; over_ff <= 1'b0;
         src_ff <= '0; dst_ff <= '0; rd_ok_ff <= 1'b0; cand_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0; found_ff <= 1'b0; idx_ff <= '0; eidx_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; over_ff <= over_in;
         rd_ok_ff <= rd_ok_in; cand_ok_ff <= cand_ok_in; rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in; idx_ff <= idx_in; eidx_ff <= eidx_in;
         if (csr_wr && csr_paddr[2] == REG_DEST[0] && csr_paddr[1:0] == 2'd0) begin
            dst_ff <= csr_pwdata[7:0];
         end
         if (csr_wr && csr_paddr[2] == REG_SOURCE[0] && csr_paddr[1:0] == 2'd0) begin
            src_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_node_ff <= rd_node_in; best_ff <= best_in; bestd_ff <= bestd_in;
      head_ff <= head_in; rsp_ff <= rsp_in;
      // hold the merged best candidate when a write to the same head lands
      if (cand_ok_in && cand_ok_ff && head_in == head_ff &&
          (!d_valid || cand_ff < d_dist) && !(cand_in < cand_ff)) begin
         cand_ff <= cand_ff;
      end else begin
         cand_ff <= cand_in;
      end
   end

   assign busy = state_ff != ST_LOAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] != 2'd0) ? 32'd0
                     : (csr_paddr[2] == REG_DEST[0]) ? {24'd0, dst_ff} : {24'd0, src_ff};

   `SPD_ASSERT(a_rsp_from_done, rsp_valid |-> $past(state_ff) == ST_DONE, "rsp outside done")
   `SPD_ASSERT(a_count_bound, count_ff <= CB'(EDGE_DEPTH), "edge count over depth")
   `SPD_ASSERT(a_idle_after_rsp, rsp_valid |-> !busy, "busy after result")
endmodule

>>> design/spd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module spd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
